// ----- sv/icb_pkg.sv -----
// Shared types, codes and default constants of the clamped-border image convolution block.
package icb_pkg;

	// Default sizes handed to the top level parameters.
	localparam int DEF_MAX_WIDTH  = 256;
	localparam int DEF_MAX_HEIGHT = 256;
	localparam int DEF_MAX_ORDER  = 15;
	localparam int DEF_FRAC_BITS  = 16;

	// Fixed field widths.
	localparam int KIND_W      = 2;
	localparam int COEF_W      = 18;
	localparam int PIX_W       = 8;
	localparam int CFG_W       = 9;
	localparam int CFG_IDX_W   = 2;
	localparam int ORDER_REG_W = 4;

	// Register values after reset.
	localparam int RESET_IMAGE_WIDTH  = 256;
	localparam int RESET_IMAGE_HEIGHT = 256;
	localparam int RESET_KERNEL_ORDER = 7;

	localparam logic [PIX_W-1:0] PIX_MAX = 8'd255;

	// Item kinds.
	localparam logic [KIND_W-1:0] KIND_WEIGHT = 2'd0;
	localparam logic [KIND_W-1:0] KIND_PIXEL  = 2'd1;
	localparam logic [KIND_W-1:0] KIND_RESULT = 2'd2;

	// Register indexes.
	localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_KERNEL_ORDER = 2'd2;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SWEEP,
		ST_DRAIN,
		ST_FINISH
	} icb_state_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic load_weight;
		logic load_pixel;
		logic start;
		logic issue;
		logic finish;
	} icb_cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic last_tap;
		logic pipe_busy;
		logic order_zero;
		logic out_free;
	} icb_sts_t;

endpackage

// ----- sv/icb_ram.sv -----
// Generic simple dual-port RAM with one write port and a registered read port.
module icb_ram
	import icb_pkg::*;
#(
	parameter int WIDTH = PIX_W,
	parameter int DEPTH = DEF_MAX_WIDTH,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

// ----- sv/icb_ctrl.sv -----
// Controller state machine: decodes transactions and sequences the tap sweep.
module icb_ctrl
	import icb_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              item_valid,
	input  logic [KIND_W-1:0] kind,
	output logic              item_ready,
	input  icb_sts_t          sts,
	output icb_cmd_t          cmd
);

	icb_state_t state_q;
	icb_state_t state_next;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_next;
		end
	end

	always_comb begin
		state_next = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (item_valid && kind == KIND_RESULT) begin
					state_next = sts.order_zero ? ST_FINISH : ST_SWEEP;
				end
			end
			ST_SWEEP: begin
				if (sts.last_tap) begin
					state_next = ST_DRAIN;
				end
			end
			ST_DRAIN: begin
				if (!sts.pipe_busy) begin
					state_next = ST_FINISH;
				end
			end
			ST_FINISH: begin
				if (sts.out_free) begin
					state_next = ST_IDLE;
				end
			end
			default: state_next = ST_IDLE;
		endcase
	end

	always_comb begin
		item_ready = 1'b0;
		cmd        = '0;
		unique case (state_q)
			ST_IDLE: begin
				item_ready = 1'b1;
				if (item_valid) begin
					unique case (kind)
						KIND_WEIGHT: cmd.load_weight = 1'b1;
						KIND_PIXEL:  cmd.load_pixel  = 1'b1;
						KIND_RESULT: cmd.start       = 1'b1;
						default:     cmd             = '0;
					endcase
				end
			end
			ST_SWEEP:  cmd.issue  = 1'b1;
			ST_DRAIN:  cmd        = '0;
			ST_FINISH: cmd.finish = sts.out_free;
			default:   cmd        = '0;
		endcase
	end

endmodule

// ----- sv/icb_dp.sv -----
// Datapath: settings, stores, load counters, tap address pipeline, multiply-accumulate, result register.
module icb_dp
	import icb_pkg::*;
#(
	parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
	parameter int MAX_HEIGHT = DEF_MAX_HEIGHT,
	parameter int MAX_ORDER  = DEF_MAX_ORDER,
	parameter int FRAC_BITS  = DEF_FRAC_BITS
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [CFG_W-1:0]     cfg_data,
	input  logic [COEF_W-1:0]    coefficient,
	input  logic [PIX_W-1:0]     pixel_in,
	input  icb_cmd_t             cmd,
	output icb_sts_t             sts,
	output logic                 result_valid,
	input  logic                 result_ready,
	output logic [PIX_W-1:0]     pixel_out,
	output logic                 last
);

	localparam int WW      = $clog2(MAX_WIDTH + 1);
	localparam int HW      = $clog2(MAX_HEIGHT + 1);
	localparam int XW      = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
	localparam int YW      = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
	localparam int OW      = $clog2(MAX_ORDER + 1);
	localparam int IMG_D   = MAX_WIDTH * MAX_HEIGHT;
	localparam int AW      = (IMG_D > 1) ? $clog2(IMG_D) : 1;
	localparam int PW      = $clog2(IMG_D + 1);
	localparam int WT_D    = MAX_ORDER * MAX_ORDER;
	localparam int KW      = (WT_D > 1) ? $clog2(WT_D) : 1;
	localparam int TW      = $clog2(WT_D + 1);
	localparam int MAX_DIM = (MAX_WIDTH > MAX_HEIGHT) ? MAX_WIDTH : MAX_HEIGHT;
	localparam int SW      = $clog2(MAX_DIM + 2 * MAX_ORDER + 1) + 1;
	localparam int PROD_W  = PIX_W + COEF_W + 1;
	localparam int ACC_W   = PROD_W + TW;
	localparam int Q_W     = ACC_W - FRAC_BITS;
	localparam int W_RST   = (RESET_IMAGE_WIDTH > MAX_WIDTH) ? MAX_WIDTH : RESET_IMAGE_WIDTH;
	localparam int H_RST   = (RESET_IMAGE_HEIGHT > MAX_HEIGHT) ? MAX_HEIGHT : RESET_IMAGE_HEIGHT;
	localparam int N_RST   = (RESET_KERNEL_ORDER > MAX_ORDER) ? MAX_ORDER : RESET_KERNEL_ORDER;

	// Settings, held in their effective (saturated) form.
	logic [WW-1:0] eff_w_q;
	logic [HW-1:0] eff_h_q;
	logic [OW-1:0] eff_n_q;
	logic [PW-1:0] total_q;
	logic [TW-1:0] taps_q;

	logic [WW-1:0]      new_w;
	logic [HW-1:0]      new_h;
	logic [OW-1:0]      new_n;
	logic [WW+HW-1:0]   tot_by_w;
	logic [WW+HW-1:0]   tot_by_h;
	logic [2*OW-1:0]    taps_sq;

	always_comb begin
		if (cfg_data == '0) begin
			new_w = WW'(1);
			new_h = HW'(1);
		end else begin
			new_w = (int'(cfg_data) > MAX_WIDTH) ? WW'(MAX_WIDTH) : WW'(cfg_data);
			new_h = (int'(cfg_data) > MAX_HEIGHT) ? HW'(MAX_HEIGHT) : HW'(cfg_data);
		end
		new_n = (int'(cfg_data[ORDER_REG_W-1:0]) > MAX_ORDER) ? OW'(MAX_ORDER)
			: OW'(cfg_data[ORDER_REG_W-1:0]);
		tot_by_w = (WW+HW)'(new_w) * (WW+HW)'(eff_h_q);
		tot_by_h = (WW+HW)'(eff_w_q) * (WW+HW)'(new_h);
		taps_sq  = (2*OW)'(new_n) * (2*OW)'(new_n);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			eff_w_q <= WW'(W_RST);
			eff_h_q <= HW'(H_RST);
			eff_n_q <= OW'(N_RST);
			total_q <= PW'(W_RST * H_RST);
			taps_q  <= TW'(N_RST * N_RST);
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_IMAGE_WIDTH: begin
					eff_w_q <= new_w;
					total_q <= tot_by_w[PW-1:0];
				end
				REG_IMAGE_HEIGHT: begin
					eff_h_q <= new_h;
					total_q <= tot_by_h[PW-1:0];
				end
				REG_KERNEL_ORDER: begin
					eff_n_q <= new_n;
					taps_q  <= taps_sq[TW-1:0];
				end
				default: begin
					eff_n_q <= eff_n_q;
				end
			endcase
		end
	end

	// Load counters. A count left out of range by a settings change restarts at zero.
	logic [TW-1:0] wcnt_q;
	logic [TW-1:0] wt_waddr;
	logic [TW-1:0] wt_wnext;
	logic [PW-1:0] pcnt_q;
	logic [PW-1:0] img_waddr;
	logic [PW-1:0] img_wnext;
	logic          wt_we;

	assign wt_waddr  = (wcnt_q >= taps_q) ? '0 : wcnt_q;
	assign wt_wnext  = wt_waddr + TW'(1);
	assign img_waddr = (pcnt_q >= total_q) ? '0 : pcnt_q;
	assign img_wnext = img_waddr + PW'(1);
	assign wt_we     = cmd.load_weight && (taps_q != '0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wcnt_q <= '0;
			pcnt_q <= '0;
		end else begin
			if (wt_we) begin
				wcnt_q <= (wt_wnext >= taps_q) ? '0 : wt_wnext;
			end
			if (cmd.load_pixel) begin
				pcnt_q <= (img_wnext >= total_q) ? '0 : img_wnext;
			end
		end
	end

	// Output position and tap counters.
	logic [XW-1:0] col_q;
	logic [YW-1:0] row_q;
	logic [OW-1:0] i_q;
	logic [OW-1:0] j_q;
	logic [KW-1:0] k_q;
	logic [OW-1:0] n_m1;
	logic [OW-1:0] mid;
	logic [WW-1:0] w_m1;
	logic [HW-1:0] h_m1;
	logic          pos_out;
	logic          at_end;

	assign n_m1    = eff_n_q - OW'(1);
	assign mid     = eff_n_q >> 1;
	assign w_m1    = eff_w_q - WW'(1);
	assign h_m1    = eff_h_q - HW'(1);
	assign pos_out = (WW'(col_q) >= eff_w_q) || (HW'(row_q) >= eff_h_q);
	assign at_end  = (WW'(col_q) == w_m1) && (HW'(row_q) == h_m1);

	// Neighbour coordinates clamped to the image edge.
	logic signed [SW-1:0] sx;
	logic signed [SW-1:0] sy;
	logic [XW-1:0]        tx;
	logic [YW-1:0]        ty;
	logic [YW+WW-1:0]     row_base;

	always_comb begin
		sx = $signed({{(SW-XW){1'b0}}, col_q}) + $signed({{(SW-OW){1'b0}}, j_q})
			- $signed({{(SW-OW){1'b0}}, mid});
		sy = $signed({{(SW-YW){1'b0}}, row_q}) + $signed({{(SW-OW){1'b0}}, i_q})
			- $signed({{(SW-OW){1'b0}}, mid});
		if (sx < 0) begin
			tx = '0;
		end else if (sx >= $signed({{(SW-WW){1'b0}}, eff_w_q})) begin
			tx = w_m1[XW-1:0];
		end else begin
			tx = sx[XW-1:0];
		end
		if (sy < 0) begin
			ty = '0;
		end else if (sy >= $signed({{(SW-HW){1'b0}}, eff_h_q})) begin
			ty = h_m1[YW-1:0];
		end else begin
			ty = sy[YW-1:0];
		end
		row_base = (YW+WW)'(ty) * (YW+WW)'(eff_w_q);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			row_q <= '0;
			i_q   <= '0;
			j_q   <= '0;
			k_q   <= '0;
		end else begin
			if (cmd.start) begin
				if (pos_out) begin
					col_q <= '0;
					row_q <= '0;
				end
				i_q <= '0;
				j_q <= '0;
				k_q <= '0;
			end else if (cmd.issue) begin
				k_q <= k_q + KW'(1);
				if (j_q == n_m1) begin
					j_q <= '0;
					i_q <= i_q + OW'(1);
				end else begin
					j_q <= j_q + OW'(1);
				end
			end else if (cmd.finish) begin
				if (at_end) begin
					col_q <= '0;
					row_q <= '0;
				end else if (WW'(col_q) == w_m1) begin
					col_q <= '0;
					row_q <= row_q + YW'(1);
				end else begin
					col_q <= col_q + XW'(1);
				end
			end
		end
	end

	// Tap pipeline: addresses, store read, multiply, accumulate.
	logic                     v_s1;
	logic                     v_s2;
	logic                     v_s3;
	logic [AW-1:0]            base_s1;
	logic [XW-1:0]            tx_s1;
	logic [KW-1:0]            k_s1;
	logic signed [PROD_W-1:0] mult_s3;
	logic signed [ACC_W-1:0]  acc_q;
	logic [PIX_W-1:0]         pix_rd;
	logic [COEF_W-1:0]        wt_rd;
	logic [AW-1:0]            img_raddr;

	assign img_raddr = base_s1 + AW'(tx_s1);

	icb_ram #(
		.WIDTH (PIX_W),
		.DEPTH (IMG_D)
	) u_image_ram (
		.clk   (clk),
		.we    (cmd.load_pixel),
		.waddr (img_waddr[AW-1:0]),
		.wdata (pixel_in),
		.raddr (img_raddr),
		.rdata (pix_rd)
	);

	icb_ram #(
		.WIDTH (COEF_W),
		.DEPTH (WT_D)
	) u_weight_ram (
		.clk   (clk),
		.we    (wt_we),
		.waddr (wt_waddr[KW-1:0]),
		.wdata (coefficient),
		.raddr (k_s1),
		.rdata (wt_rd)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else begin
			v_s1 <= cmd.issue;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.issue) begin
			base_s1 <= row_base[AW-1:0];
			tx_s1   <= tx;
			k_s1    <= k_q;
		end
		mult_s3 <= $signed({1'b0, pix_rd}) * $signed(wt_rd);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q <= '0;
		end else if (cmd.start) begin
			acc_q <= '0;
		end else if (v_s3) begin
			acc_q <= acc_q + ACC_W'(mult_s3);
		end
	end

	// Drop the fraction bits, then clamp to the pixel range.
	logic [Q_W-1:0]   acc_int;
	logic [PIX_W-1:0] sat_pix;

	always_comb begin
		acc_int = acc_q[ACC_W-1:FRAC_BITS];
		if (acc_q < 0) begin
			sat_pix = '0;
		end else if (acc_int > Q_W'(PIX_MAX)) begin
			sat_pix = PIX_MAX;
		end else begin
			sat_pix = acc_int[PIX_W-1:0];
		end
	end

	// Output register.
	logic             out_valid_q;
	logic [PIX_W-1:0] pixel_out_q;
	logic             last_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.finish) begin
			out_valid_q <= 1'b1;
		end else if (result_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.finish) begin
			pixel_out_q <= sat_pix;
			last_q      <= at_end;
		end
	end

	assign result_valid = out_valid_q;
	assign pixel_out    = pixel_out_q;
	assign last         = last_q;

	assign sts.last_tap   = (i_q == n_m1) && (j_q == n_m1);
	assign sts.pipe_busy  = v_s1 || v_s2 || v_s3;
	assign sts.order_zero = (eff_n_q == '0);
	assign sts.out_free   = !out_valid_q || result_ready;

endmodule

// ----- sv/image_convolution_clamped_border.sv -----
// Top level of the clamped-border image convolution block: controller, datapath and checks.
// Coefficient and pixel load transactions may follow back to back. A result request of kernel
// order n sweeps n*n taps, one tap a cycle through the single shared multiply-accumulate
// pipeline, and then drains it; at order zero it goes straight to finishing. The result is
// registered once the output is free, and the next transaction is taken after that.
// Reset clears the settings to 256 x 256 with order 7, and clears all counters and valids;
// the image and weight stores are not cleared and must be written before they are read.
module image_convolution_clamped_border
	import icb_pkg::*;
#(
	parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
	parameter int MAX_HEIGHT = DEF_MAX_HEIGHT,
	parameter int MAX_ORDER  = DEF_MAX_ORDER,
	parameter int FRAC_BITS  = DEF_FRAC_BITS
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [CFG_W-1:0]     cfg_data,
	input  logic                 item_valid,
	output logic                 item_ready,
	input  logic [KIND_W-1:0]    kind,
	input  logic [COEF_W-1:0]    coefficient,
	input  logic [PIX_W-1:0]     pixel_in,
	output logic                 result_valid,
	input  logic                 result_ready,
	output logic [PIX_W-1:0]     pixel_out,
	output logic                 last
);

	// The controller only ever accepts a transaction in its idle state. Load transactions
	// are carried out on the cycle of acceptance; a result request starts a sweep over the
	// kernel taps, which the datapath pipelines one tap per cycle.
	icb_cmd_t cmd;
	icb_sts_t sts;

	icb_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_valid (item_valid),
		.kind       (kind),
		.item_ready (item_ready),
		.sts        (sts),
		.cmd        (cmd)
	);

	// The datapath holds the output register, so further load transactions are taken while
	// a finished result still waits for the downstream side.
	icb_dp #(
		.MAX_WIDTH  (MAX_WIDTH),
		.MAX_HEIGHT (MAX_HEIGHT),
		.MAX_ORDER  (MAX_ORDER),
		.FRAC_BITS  (FRAC_BITS)
	) u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.coefficient  (coefficient),
		.pixel_in     (pixel_in),
		.cmd          (cmd),
		.sts          (sts),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.pixel_out    (pixel_out),
		.last         (last)
	);

`ifndef SYNTHESIS
	// A result request must take the block out of its idle state on the next cycle.
	a_request_blocks: assert property (@(posedge clk) disable iff (!arst_n)
		item_valid && item_ready && kind == KIND_RESULT |=> !item_ready)
		else $error("input still ready right after a result request");

	// Completing a result always leaves a valid result in the output register.
	a_finish_shows: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.finish |=> result_valid)
		else $error("result not presented after completion");

	// A load or ignored transaction never produces a result.
	a_load_silent: assert property (@(posedge clk) disable iff (!arst_n)
		item_valid && item_ready && kind != KIND_RESULT && !result_valid |=> !result_valid)
		else $error("result appeared after a load transaction");

	// Taps are issued only while no transaction can be accepted.
	a_issue_busy: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.issue |-> !item_ready && !cmd.finish)
		else $error("tap issued while idle or finishing");
`endif

endmodule
